>>> src/foxm_pkg.sv
// ---------------------------------------------------------------------------
// foxm_pkg: shared constants and functions of the X-drive mixer
// Holds the arctangent table, command codes and fixed-point helpers.
// ---------------------------------------------------------------------------
package foxm_pkg;

	localparam int ANGLE_BITS_DEF = 16;
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TAB_LEN = 24;
	localparam int FRAC = 14;
	// Vector width: 11-bit input, 14 fraction bits, growth and swap headroom.
	localparam int VW = 29;
	localparam logic [31:0] INVK_BASE = 32'd652032874;
	localparam logic [31:0] INVK_TAIL = 32'd434688583;

	localparam logic [1:0] CMD_ROBOT = 2'd0;
	localparam logic [1:0] CMD_FIELD = 2'd1;
	localparam logic [1:0] CMD_PIVOT = 2'd2;

	localparam logic [0:0] REG_HEADING_OFFSET = 1'd0;

	typedef logic [31:0] tab_t [TAB_LEN];
	localparam tab_t ATAN_TAB = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};

	// Arctangent of step i, rounded half up to an angle of ab bits.
	function automatic logic [31:0] atan_step(input int i, input int ab);
		logic [32:0] t;
		t = {1'b0, ATAN_TAB[i]} + (33'd1 << (31 - ab));
		return 32'(t >> (32 - ab));
	endfunction

	// Inverse CORDIC gain in Q30 for n stages.
	function automatic logic [31:0] invk(input int n);
		return INVK_BASE + (INVK_TAIL >> (2 * n));
	endfunction

	typedef struct packed {
		logic [1:0]  cmd;
		logic        zero_xy;
		logic [10:0] turn;
	} ctl_t;

endpackage

>>> src/field_oriented_xdrive_mixer.sv
// ---------------------------------------------------------------------------
// field_oriented_xdrive_mixer: X-drive wheel mixer with field orientation
// Rotates field and pivot drive requests by the heading and computes pivot
// turns with a chain of CORDIC cells, then mixes the four wheel velocities.
// ---------------------------------------------------------------------------
// Usage: a command is one transfer on the input channel (valid/ready) with
// cmd, x_drive, y_drive, turn_request and heading. Each command yields one
// transfer on the output channel with the four wheel velocities and the
// moving flag, in command order.
// The pipeline registers the quadrant setup, then each CORDIC cell, then
// the gain removal and angle conversion stages, then the wheel sums.
// One command is taken every cycle while the output is not stalled.
// The whole pipeline advances together; when the receiver stalls and the
// output register holds an untaken result, the pipeline freezes and ready
// drops, so nothing is lost. Ready stays high while the output is empty
// or being taken.
// Reset clears all valid flags and heading_offset to zero. heading_offset
// is written over the APB port at address 0 and may be read back.
// ---------------------------------------------------------------------------
module field_oriented_xdrive_mixer #(
	parameter int ANGLE_BITS = foxm_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STAGES = foxm_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [1:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [10:0] x_drive,
	input  logic signed [10:0] y_drive,
	input  logic signed [10:0] turn_request,
	input  logic [15:0]        heading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [12:0] front_left,
	output logic signed [12:0] front_right,
	output logic signed [12:0] back_left,
	output logic signed [12:0] back_right,
	output logic               moving
);
	localparam int VW = foxm_pkg::VW;
	localparam int AW = ANGLE_BITS + 2;
	localparam int N = (CORDIC_STAGES < foxm_pkg::TAB_LEN) ? CORDIC_STAGES : foxm_pkg::TAB_LEN;
	localparam logic signed [AW-1:0] Q = AW'(1) <<< (ANGLE_BITS - 2);
	localparam logic [31:0] INVK = foxm_pkg::invk(N);
	localparam logic [1:0] OFFSET_ADDR = 2'(foxm_pkg::REG_HEADING_OFFSET * 4);

	// Register port.
	logic [15:0] heading_offset_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_offset_q <= '0;
		end else if (psel && penable && pwrite && paddr == OFFSET_ADDR) begin
			heading_offset_q <= pwdata[15:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr == OFFSET_ADDR) prdata = {16'd0, heading_offset_q};
	end

	function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [15:0] v);
		if (ANGLE_BITS >= 16) return ANGLE_BITS'({v, {(ANGLE_BITS > 16 ? ANGLE_BITS-16 : 1){1'b0}}}
			>> (ANGLE_BITS > 16 ? 0 : 1));
		else return ANGLE_BITS'(v >> (16 - ANGLE_BITS));
	endfunction

	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// Setup stage: quadrant corrections for both CORDIC paths.
	logic [ANGLE_BITS-1:0] h;
	logic signed [VW-1:0] x0, y0, rx0, ry0, vx0, vy0;
	logic signed [AW-1:0] rz0, vz0;
	foxm_pkg::ctl_t c0;
	always_comb begin
		h = to_angle(heading);
		x0 = VW'(x_drive) <<< foxm_pkg::FRAC;
		y0 = VW'(y_drive) <<< foxm_pkg::FRAC;
		rz0 = AW'({2'b00, h});
		if (rz0 >= 2 * Q) rz0 = AW'(rz0 - 4 * Q);
		rx0 = x0; ry0 = y0;
		if (rz0 > Q) begin
			rx0 = -y0; ry0 = x0; rz0 = rz0 - Q;
		end else if (rz0 < -Q) begin
			rx0 = y0; ry0 = -x0; rz0 = rz0 + Q;
		end
		vx0 = y0; vy0 = x0; vz0 = '0;
		if (y0 < 0) begin
			if (x0 >= 0) begin
				vx0 = x0; vy0 = -y0; vz0 = Q;
			end else begin
				vx0 = -x0; vy0 = y0; vz0 = -Q;
			end
		end
		c0.cmd = cmd;
		c0.zero_xy = (x_drive == '0) && (y_drive == '0);
		c0.turn = turn_request;
	end

	logic v_s1;
	foxm_pkg::ctl_t c_s1;
	logic signed [VW-1:0] rx_s1, ry_s1, vx_s1, vy_s1;
	logic signed [AW-1:0] rz_s1, vz_s1;
	logic [ANGLE_BITS-1:0] h_s1;
	logic [ANGLE_BITS-1:0] hp [N+1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= c0; rx_s1 <= rx0; ry_s1 <= ry0; rz_s1 <= rz0;
			vx_s1 <= vx0; vy_s1 <= vy0; vz_s1 <= vz0; h_s1 <= h;
		end
	end

	// Chain of cells.
	logic v_c [N+1];
	foxm_pkg::ctl_t c_c [N+1];
	logic signed [VW-1:0] rx_c [N+1], ry_c [N+1], vx_c [N+1], vy_c [N+1];
	logic signed [AW-1:0] rz_c [N+1], vz_c [N+1];
	assign v_c[0] = v_s1; assign c_c[0] = c_s1;
	assign rx_c[0] = rx_s1; assign ry_c[0] = ry_s1; assign rz_c[0] = rz_s1;
	assign vx_c[0] = vx_s1; assign vy_c[0] = vy_s1; assign vz_c[0] = vz_s1;
	assign hp[0] = h_s1;

	for (genvar i = 0; i < N; i++) begin : g_cell
		foxm_cell #(.ANGLE_BITS(ANGLE_BITS), .IDX(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.v_in(v_c[i]), .c_in(c_c[i]),
			.rx_in(rx_c[i]), .ry_in(ry_c[i]), .rz_in(rz_c[i]),
			.vx_in(vx_c[i]), .vy_in(vy_c[i]), .vz_in(vz_c[i]),
			.v_q(v_c[i+1]), .c_q(c_c[i+1]),
			.rx_q(rx_c[i+1]), .ry_q(ry_c[i+1]), .rz_q(rz_c[i+1]),
			.vx_q(vx_c[i+1]), .vy_q(vy_c[i+1]), .vz_q(vz_c[i+1]));
		always_ff @(posedge clk) begin
			if (en) hp[i+1] <= hp[i];
		end
	end

	// Gain removal multiply and pivot angle difference.
	logic v_s2;
	foxm_pkg::ctl_t c_s2;
	logic signed [VW+33-1:0] px_s2, py_s2;
	logic signed [AW-1:0] s_s2;
	logic [ANGLE_BITS-1:0] d;
	logic signed [AW-1:0] s_d;
	localparam logic signed [VW+33-1:0] RND = (VW+33)'(1) <<< (30 + foxm_pkg::FRAC - 1);
	always_comb begin
		d = ANGLE_BITS'(vz_c[N]) - hp[N] + to_angle(heading_offset_q);
		s_d = AW'({1'b0, d[ANGLE_BITS-2:0]});
		if (s_d > Q) s_d = AW'(s_d - 2 * Q);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_c[N];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s2 <= c_c[N];
			px_s2 <= (VW+33)'(rx_c[N]) * $signed({1'b0, INVK}) + RND;
			py_s2 <= (VW+33)'(ry_c[N]) * $signed({1'b0, INVK}) + RND;
			s_s2 <= s_d;
		end
	end

	// Rounding and degree conversion.
	logic v_s3;
	foxm_pkg::ctl_t c_s3;
	logic signed [12:0] xa_s3, ya_s3, t_s3;
	logic signed [AW+10-1:0] deg;
	always_comb begin
		deg = (AW+10)'(s_s2) * (AW+10)'(360) + ((AW+10)'(1) <<< (ANGLE_BITS - 1));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			c_s3 <= c_s2;
			if (c_s2.cmd == foxm_pkg::CMD_FIELD || c_s2.cmd == foxm_pkg::CMD_PIVOT) begin
				xa_s3 <= -13'(py_s2 >>> (30 + foxm_pkg::FRAC));
				ya_s3 <= 13'(px_s2 >>> (30 + foxm_pkg::FRAC));
			end else begin
				xa_s3 <= '0;
				ya_s3 <= '0;
			end
			if (c_s2.cmd == foxm_pkg::CMD_PIVOT)
				t_s3 <= c_s2.zero_xy ? 13'sd0 : 13'(deg >>> ANGLE_BITS);
			else
				t_s3 <= 13'($signed(c_s2.turn));
		end
	end

	// Robot mode needs the raw requests; they ride along in a delay line
	// that is as deep as the path up to the third stage.
	logic signed [10:0] xr [N+4], yr [N+4];
	assign xr[0] = x_drive; assign yr[0] = y_drive;
	for (genvar j = 0; j < N + 3; j++) begin : g_raw
		always_ff @(posedge clk) begin
			if (en) begin
				xr[j+1] <= xr[j];
				yr[j+1] <= yr[j];
			end
		end
	end

	// Wheel mixing into the output register.
	logic signed [12:0] xa, ya;
	always_comb begin
		if (c_s3.cmd == foxm_pkg::CMD_FIELD || c_s3.cmd == foxm_pkg::CMD_PIVOT) begin
			xa = xa_s3; ya = ya_s3;
		end else begin
			xa = 13'(xr[N+3]); ya = 13'(yr[N+3]);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			front_left  <= t_s3 + ya + xa;
			front_right <= t_s3 - ya + xa;
			back_left   <= t_s3 + ya - xa;
			back_right  <= t_s3 - ya - xa;
			moving      <= (t_s3 != 0) || (xa != 0) || (ya != 0);
		end
	end
endmodule

>>> src/foxm_cell.sv
// ---------------------------------------------------------------------------
// foxm_cell: one CORDIC micro-rotation cell
// Runs one rotation step on the field vector and one vectoring step on the
// direction vector, then registers both for the next cell.
// ---------------------------------------------------------------------------
module foxm_cell #(
	parameter int ANGLE_BITS = foxm_pkg::ANGLE_BITS_DEF,
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          v_in,
	input  foxm_pkg::ctl_t                c_in,
	input  logic signed [foxm_pkg::VW-1:0] rx_in,
	input  logic signed [foxm_pkg::VW-1:0] ry_in,
	input  logic signed [ANGLE_BITS+1:0]  rz_in,
	input  logic signed [foxm_pkg::VW-1:0] vx_in,
	input  logic signed [foxm_pkg::VW-1:0] vy_in,
	input  logic signed [ANGLE_BITS+1:0]  vz_in,
	output logic                          v_q,
	output foxm_pkg::ctl_t                c_q,
	output logic signed [foxm_pkg::VW-1:0] rx_q,
	output logic signed [foxm_pkg::VW-1:0] ry_q,
	output logic signed [ANGLE_BITS+1:0]  rz_q,
	output logic signed [foxm_pkg::VW-1:0] vx_q,
	output logic signed [foxm_pkg::VW-1:0] vy_q,
	output logic signed [ANGLE_BITS+1:0]  vz_q
);
	localparam logic signed [ANGLE_BITS+1:0] STEP =
		(ANGLE_BITS+2)'(foxm_pkg::atan_step(IDX, ANGLE_BITS));

	logic signed [foxm_pkg::VW-1:0] rdx, rdy, vdx, vdy;
	assign rdx = ry_in >>> IDX;
	assign rdy = rx_in >>> IDX;
	assign vdx = vy_in >>> IDX;
	assign vdy = vx_in >>> IDX;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_q <= c_in;
			if (!rz_in[ANGLE_BITS+1]) begin
				rx_q <= rx_in - rdx;
				ry_q <= ry_in + rdy;
				rz_q <= rz_in - STEP;
			end else begin
				rx_q <= rx_in + rdx;
				ry_q <= ry_in - rdy;
				rz_q <= rz_in + STEP;
			end
			if (vy_in > 0) begin
				vx_q <= vx_in + vdx;
				vy_q <= vy_in - vdy;
				vz_q <= vz_in + STEP;
			end else begin
				vx_q <= vx_in - vdx;
				vy_q <= vy_in + vdy;
				vz_q <= vz_in - STEP;
			end
		end
	end
endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the field-oriented X-drive mixer
// Drives robot, field and pivot commands through the valid/ready input with
// bursty traffic and a stalling receiver. Each command's wheel velocities
// are predicted in the bench and checked in order. The heading offset
// register is swept through several values between phases.
// ---------------------------------------------------------------------------
module testbench;

	localparam int AB = 16;
	localparam int STAGES = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = STAGES + 12;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic signed [12:0] fl;
		logic signed [12:0] fr;
		logic signed [12:0] bl;
		logic signed [12:0] br;
		logic               mv;
	} wheels_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [1:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         cmd;
	logic signed [10:0] x_drive;
	logic signed [10:0] y_drive;
	logic signed [10:0] turn_request;
	logic [15:0]        heading;
	logic               out_valid;
	logic               out_ready;
	logic signed [12:0] front_left;
	logic signed [12:0] front_right;
	logic signed [12:0] back_left;
	logic signed [12:0] back_right;
	logic               moving;

	// The bench's own copy of the heading offset register.
	logic [15:0] offset_shadow;
	wheels_t     expected_wheels[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          commands_sent;
	int          idle_cycles = 0;
	int          burst_left;
	int          pivot_count;
	bit          hold_request;

	field_oriented_xdrive_mixer u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .x_drive(x_drive), .y_drive(y_drive),
		.turn_request(turn_request), .heading(heading),
		.out_valid(out_valid), .out_ready(out_ready),
		.front_left(front_left), .front_right(front_right),
		.back_left(back_left), .back_right(back_right), .moving(moving)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Arctangent of CORDIC step i as an angle of AB bits, rounded half up.
	function automatic longint step_angle(input int i);
		return longint'(({32'd0, foxm_pkg::ATAN_TAB[i]} + (64'd1 << (31 - AB))) >> (32 - AB));
	endfunction

	// Removes the CORDIC gain and rounds to an integer velocity.
	function automatic longint remove_gain(input longint v);
		longint k;
		k = longint'(foxm_pkg::INVK_BASE) + (longint'(foxm_pkg::INVK_TAIL) >>> (2 * STAGES));
		return (v * k + (64'sd1 <<< 43)) >>> 44;
	endfunction

	// Rotates the request vector by angle a (fraction of a turn).
	function automatic void rotate_vec(input longint x, input longint y, input longint a,
			output longint rx, output longint ry);
		longint vx, vy, z, q, t, dx, dy;
		vx = x <<< foxm_pkg::FRAC;
		vy = y <<< foxm_pkg::FRAC;
		q = 64'sd1 <<< (AB - 2);
		z = a;
		if (z >= 2 * q) z -= 4 * q;
		// Quarter-turn pre-rotation keeps the residual angle in CORDIC range.
		if (z > q) begin
			t = vx; vx = -vy; vy = t; z -= q;
		end else if (z < -q) begin
			t = vx; vx = vy; vy = -t; z += q;
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (z >= 0) begin
				vx -= dx; vy += dy; z -= step_angle(i);
			end else begin
				vx += dx; vy -= dy; z += step_angle(i);
			end
		end
		rx = remove_gain(vx);
		ry = remove_gain(vy);
	endfunction

	// Travel direction atan2(num, den) as a signed turn fraction.
	function automatic longint travel_angle(input longint num, input longint den);
		longint vx, vy, z, q, t, dx, dy;
		vx = den <<< foxm_pkg::FRAC;
		vy = num <<< foxm_pkg::FRAC;
		q = 64'sd1 <<< (AB - 2);
		z = 0;
		if (vx < 0) begin
			if (vy >= 0) begin
				t = vx; vx = vy; vy = -t; z = q;
			end else begin
				t = vx; vx = -vy; vy = t; z = -q;
			end
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (vy > 0) begin
				vx += dx; vy -= dy; z += step_angle(i);
			end else begin
				vx -= dx; vy += dy; z -= step_angle(i);
			end
		end
		return z;
	endfunction

	function automatic logic signed [12:0] clamp_wheel(input longint v);
		if (v > 4095) v = 4095;
		if (v < -4096) v = -4096;
		return v[12:0];
	endfunction

	function automatic wheels_t mix_wheels(input logic [1:0] c, input logic signed [10:0] xi,
			input logic signed [10:0] yi, input logic signed [10:0] ti, input logic [15:0] h);
		wheels_t w;
		longint x, y, turn, xa, ya, rx, ry, half, q, d, s, mask;
		x = xi;
		y = yi;
		turn = ti;
		xa = x;
		ya = y;
		half = 64'sd1 <<< (AB - 1);
		q = 64'sd1 <<< (AB - 2);
		mask = (64'sd1 <<< AB) - 1;
		if (c == foxm_pkg::CMD_PIVOT) begin
			if (x == 0 && y == 0) begin
				turn = 0;
			end else begin
				// Heading error folded into a half turn, the upper edge giving +90.
				d = (travel_angle(x, y) - longint'(h) + longint'(offset_shadow)) & mask;
				s = d & (half - 1);
				if (s > q) s -= half;
				turn = (s * 360 + half) >>> AB;
			end
		end
		if (c == foxm_pkg::CMD_FIELD || c == foxm_pkg::CMD_PIVOT) begin
			rotate_vec(x, y, longint'(h), rx, ry);
			xa = -ry;
			ya = rx;
		end
		w.fl = clamp_wheel(turn + ya + xa);
		w.fr = clamp_wheel(turn - ya + xa);
		w.bl = clamp_wheel(turn + ya - xa);
		w.br = clamp_wheel(turn - ya - xa);
		w.mv = (turn != 0 || xa != 0 || ya != 0);
		return w;
	endfunction

	// Offers one command and returns once it has been transferred. Valid is
	// left high so that back-to-back commands need no lowering.
	task automatic send_command(input logic [1:0] c, input logic signed [10:0] xi,
			input logic signed [10:0] yi, input logic signed [10:0] ti, input logic [15:0] h);
		in_valid <= 1'b1;
		cmd <= c;
		x_drive <= xi;
		y_drive <= yi;
		turn_request <= ti;
		heading <= h;
		do @(posedge clk); while (!in_ready);
		expected_wheels.push_back(mix_wheels(c, xi, yi, ti, h));
		commands_sent++;
		if (c == foxm_pkg::CMD_PIVOT) pivot_count++;
		// Bursts of random length separated by random gaps; about a third of
		// the bursts run with no gap at all.
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 20);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_wheels.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// Register write: setup cycle, then access cycle (pready is always high).
	task automatic write_offset(input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 2'(foxm_pkg::REG_HEADING_OFFSET * 4);
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		offset_shadow = value;
		@(posedge clk);
	endtask

	function automatic logic signed [10:0] random_velocity();
		case ($urandom_range(0, 9))
			0: return -11'sd1024;
			1: return 11'sd1023;
			2: return 11'sd0;
			3: return 11'($urandom_range(0, 8)) - 11'sd4;
			default: return 11'($urandom);
		endcase
	endfunction

	task automatic send_random(input int count);
		logic [1:0] c;
		logic signed [10:0] xi, yi;
		for (int n = 0; n < count; n++) begin
			c = 2'($urandom_range(0, 3));
			xi = random_velocity();
			yi = random_velocity();
			// Pivot with no travel direction has its own turn rule.
			if (c == foxm_pkg::CMD_PIVOT && $urandom_range(0, 9) == 0) begin
				xi = 0;
				yi = 0;
			end
			send_command(c, xi, yi, random_velocity(), 16'($urandom));
		end
	endtask

	// Field extremes, every command code, zero travel in pivot and headings
	// at each quarter turn and just beside three of them.
	task automatic test_directed();
		send_command(foxm_pkg::CMD_ROBOT, 0, 0, 0, 16'h0000);
		send_command(foxm_pkg::CMD_ROBOT, 11'sd1023, 11'sd1023, 11'sd1023, 16'hFFFF);
		send_command(foxm_pkg::CMD_ROBOT, -11'sd1024, -11'sd1024, -11'sd1024, 16'h0000);
		send_command(foxm_pkg::CMD_ROBOT, 11'sd1023, -11'sd1024, 11'sd5, 16'h1234);
		send_command(foxm_pkg::CMD_FIELD, 11'sd1023, 11'sd0, 11'sd0, 16'h0000);
		send_command(foxm_pkg::CMD_FIELD, 11'sd0, 11'sd1023, 11'sd0, 16'h4000);
		send_command(foxm_pkg::CMD_FIELD, -11'sd1024, -11'sd1024, 11'sd1023, 16'h8000);
		send_command(foxm_pkg::CMD_FIELD, 11'sd1023, -11'sd1024, -11'sd1024, 16'hC000);
		send_command(foxm_pkg::CMD_FIELD, 11'sd300, 11'sd700, 11'sd0, 16'h4001);
		send_command(foxm_pkg::CMD_FIELD, -11'sd300, 11'sd700, 11'sd0, 16'hBFFF);
		send_command(foxm_pkg::CMD_FIELD, 11'sd1, 11'sd0, 11'sd0, 16'hFFFF);
		send_command(foxm_pkg::CMD_PIVOT, 11'sd0, 11'sd0, 11'sd1023, 16'h2000);
		send_command(foxm_pkg::CMD_PIVOT, 11'sd0, 11'sd500, 11'sd7, 16'h0000);
		send_command(foxm_pkg::CMD_PIVOT, 11'sd500, 11'sd0, 11'sd0, 16'h0000);
		send_command(foxm_pkg::CMD_PIVOT, 11'sd0, -11'sd500, 11'sd0, 16'h0000);
		send_command(foxm_pkg::CMD_PIVOT, -11'sd1024, -11'sd1024, 11'sd0, 16'hFFFF);
		send_command(foxm_pkg::CMD_PIVOT, 11'sd1023, 11'sd1023, -11'sd1024, 16'h6000);
		send_command(foxm_pkg::CMD_PIVOT, 11'sd0, 11'sd400, 11'sd0, 16'h4000);
		send_command(foxm_pkg::CMD_PIVOT, 11'sd0, 11'sd400, 11'sd0, 16'hC000);
		send_command(2'd3, 11'sd200, -11'sd100, 11'sd50, 16'h4000);
		send_command(2'd3, -11'sd1024, 11'sd1023, 11'sd1023, 16'hFFFF);
		go_idle();
	endtask

	// Phases of random commands under several offsets, extremes included.
	task automatic test_offset_sweep();
		logic [15:0] offsets[5];
		offsets = '{16'hFFFF, 16'h4000, 16'($urandom), 16'h8000, 16'h0000};
		foreach (offsets[k]) begin
			write_offset(offsets[k]);
			send_command(foxm_pkg::CMD_PIVOT, 11'sd0, 11'sd400, 11'sd0, 16'h0000);
			send_random(130);
			go_idle();
		end
	endtask

	// The receiver holds off for a long stretch while commands keep coming,
	// so the pipeline fills and the input must stall.
	task automatic test_backpressure();
		hold_request = 1'b1;
		send_random(120);
		go_idle();
	endtask

	task automatic test_random();
		write_offset(16'($urandom));
		send_random(150);
		go_idle();
	endtask

	// Receiver: cycles through always-ready, coin-flip and mostly-stalled
	// stretches, and on request holds off until a countdown from HOLD_CYCLES runs out.
	initial begin
		int cyc;
		int hold_left;
		cyc = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case ((cyc / 64) % 3)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Checks every output transfer against the oldest prediction.
	always @(posedge clk) begin
		wheels_t got, want;
		if (out_valid && out_ready) begin
			got = '{front_left, front_right, back_left, back_right, moving};
			results_seen++;
			if (expected_wheels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result fl=%0d fr=%0d bl=%0d br=%0d mv=%0b",
						$realtime, got.fl, got.fr, got.bl, got.br, got.mv);
			end else begin
				want = expected_wheels.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: mismatch expected fl=%0d fr=%0d bl=%0d br=%0d mv=%0b",
							$realtime, want.fl, want.fr, want.bl, want.br, want.mv);
						$display("%0t:          got      fl=%0d fr=%0d bl=%0d br=%0d mv=%0b",
							$realtime, got.fl, got.fr, got.bl, got.br, got.mv);
					end
				end
			end
		end
	end

	// Watchdog: ends the run after too many cycles with no transfer at all.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && expected_wheels.size() != 0 ||
				idle_cycles >= 4 * WATCHDOG_LIMIT) begin
			$display("timeout after %0d cycles without a transfer", idle_cycles);
			$display("testbench: FAIL");
			$finish;
		end
	end

	initial begin
		commands_sent = 0;
		burst_left = 0;
		pivot_count = 0;
		hold_request = 1'b0;
		offset_shadow = 16'd0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		cmd <= foxm_pkg::CMD_ROBOT;
		x_drive <= '0;
		y_drive <= '0;
		turn_request <= '0;
		heading <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_offset_sweep();
		test_backpressure();
		test_random();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d commands (%0d pivot) and %0d results over six offsets,",
			commands_sent, pivot_count, results_seen);
		$display("with bursty input, receiver stalls and one long output hold-off");
		if (mismatches == 0 && expected_wheels.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				expected_wheels.size());
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
